### design/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg - shared definitions for the wildcard pattern matcher
// Sizes, operation codes and the control bundle sent to every match cell.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_TEXT    = 1048576;

  localparam int SYM_W = 5;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = $clog2(MAX_TEXT + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = ((1 + 2 * POS_W + 7) / 8) * 8;

  localparam logic [SYM_W-1:0] SYM_WILD = '0;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_TEXT    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  typedef struct packed {
    logic clear_pat;
    logic push_pat;
    logic clear_txt;
    logic push_txt;
  } cell_ctrl_t;

  function automatic logic sym_agree(logic [SYM_W-1:0] p, logic [SYM_W-1:0] t);
    return (p == SYM_WILD) || (t == SYM_WILD) || (p == t);
  endfunction

endpackage

### design/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell - one position of the match chain
// Holds one pattern symbol with its valid bit and one text symbol. Both
// shift towards the older end of the chain; the cell flags whether its
// pattern symbol agrees with the text symbol arriving from its neighbour.
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wpm_pkg::cell_ctrl_t       ctrl,
  input  logic [wpm_pkg::SYM_W-1:0] pat_in,
  input  logic                      pval_in,
  input  logic [wpm_pkg::SYM_W-1:0] txt_in,
  output logic [wpm_pkg::SYM_W-1:0] pat_o,
  output logic                      pval_o,
  output logic [wpm_pkg::SYM_W-1:0] txt_o,
  output logic                      agree_o
);

  logic [wpm_pkg::SYM_W-1:0] pat_r;
  logic                      pval_r;
  logic [wpm_pkg::SYM_W-1:0] txt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pval_r <= 1'b0;
    end else if (ctrl.clear_pat) begin
      pval_r <= 1'b0;
    end else if (ctrl.push_pat) begin
      pval_r <= pval_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_pat) begin
      pat_r <= pat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txt_r <= '0;
    end else if (ctrl.clear_txt) begin
      txt_r <= '0;
    end else if (ctrl.push_txt) begin
      txt_r <= txt_in;
    end
  end

  // compare against the symbol about to land here, so the verdict is ready
  // in the same cycle as the text transfer
  assign agree_o = !pval_r || wpm_pkg::sym_agree(pat_r, txt_in);

  assign pat_o  = pat_r;
  assign pval_o = pval_r;
  assign txt_o  = txt_r;

endmodule

### design/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher - streaming wildcard string matcher
// Compares the pattern against the latest text window in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; in_tuser carries the operation (clear
//           all, append pattern symbol, text symbol, restart text), in_tdata
//           the symbol (0 is the wildcard, 1..26 the letters).
//   out_* : one result per text symbol taken while fewer than MAX_TEXT text
//           symbols have been seen; other operations give no result.
//   Pattern appends shift the pattern chain by one cell, text symbols shift
//   the text chain, so cell j always pairs the right pattern and text
//   symbols and every cell compares in parallel.
//   A result is in the output register the cycle after its text transfer.
//   Throughput: one command per cycle unless the receiver stalls, with a
//   combinational compare across all MAX_PATTERN cells and AND of verdicts.
//   Reset empties the pattern, zeroes the text window, position and count.
//   When the receiver stalls, the held result stays in the output register
//   and in_tready falls until it is taken; a result leaving in the same
//   cycle lets a new command in.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wpm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [4:0] symbol
  input  logic [wpm_pkg::IN_TUSER_W-1:0]  in_tuser,   // [1:0] opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wpm_pkg::OUT_TDATA_W-1:0] out_tdata   // match, start_position,
                                                      // match_count
);

  localparam int NC = wpm_pkg::MAX_PATTERN;
  localparam int PW = wpm_pkg::POS_W;
  localparam logic [PW-1:0] MAX_TEXT_C = PW'(wpm_pkg::MAX_TEXT);
  localparam logic [wpm_pkg::LEN_W-1:0] MAX_LEN_C = wpm_pkg::LEN_W'(NC);

  wpm_pkg::opcode_t          op;
  logic [wpm_pkg::SYM_W-1:0] sym;
  logic                      in_xfer;
  wpm_pkg::cell_ctrl_t       ctrl;

  logic [wpm_pkg::SYM_W-1:0] pat_c  [NC];
  logic [wpm_pkg::SYM_W-1:0] txt_c  [NC];
  logic [NC-1:0]             pval_c;
  logic [NC-1:0]             agree_c;

  logic [wpm_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic [PW-1:0]             cnt_r, cnt_nxt;
  logic                      text_take;
  logic [PW-1:0]             pos_inc;
  logic [PW-1:0]             len_ext;
  logic                      full_win;
  logic                      hit;
  logic [PW-1:0]             start;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_match_r;
  logic [PW-1:0]             out_start_r;
  logic [PW-1:0]             out_cnt_r;

  assign op        = wpm_pkg::opcode_t'(in_tuser[1:0]);
  assign sym       = in_tdata[wpm_pkg::SYM_W-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign text_take = in_xfer && (op == wpm_pkg::OP_TEXT) && (pos_r < MAX_TEXT_C);

  always_comb begin
    ctrl.clear_pat = in_xfer && (op == wpm_pkg::OP_CLEAR);
    ctrl.push_pat  = in_xfer && (op == wpm_pkg::OP_APPEND) && (len_r < MAX_LEN_C);
    ctrl.clear_txt = in_xfer && ((op == wpm_pkg::OP_CLEAR) || (op == wpm_pkg::OP_RESTART));
    ctrl.push_txt  = text_take;
  end

  for (genvar j = 0; j < NC; j++) begin : g_cell
    logic [wpm_pkg::SYM_W-1:0] pat_in;
    logic                      pval_in;
    logic [wpm_pkg::SYM_W-1:0] txt_in;

    if (j == 0) begin : g_head
      assign pat_in  = sym;
      assign pval_in = 1'b1;
      assign txt_in  = sym;
    end else begin : g_body
      assign pat_in  = pat_c[j-1];
      assign pval_in = pval_c[j-1];
      assign txt_in  = txt_c[j-1];
    end

    wpm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .pat_in  (pat_in),
      .pval_in (pval_in),
      .txt_in  (txt_in),
      .pat_o   (pat_c[j]),
      .pval_o  (pval_c[j]),
      .txt_o   (txt_c[j]),
      .agree_o (agree_c[j])
    );
  end

  always_comb begin
    pos_inc  = pos_r + PW'(1);
    len_ext  = PW'(len_r);
    full_win = (len_r != '0) && (pos_inc >= len_ext);
    hit      = full_win && (&agree_c);
    start    = full_win ? (pos_inc - len_ext + PW'(1)) : '0;
  end

  always_comb begin
    len_nxt = len_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (ctrl.clear_pat) begin
      len_nxt = '0;
    end else if (ctrl.push_pat) begin
      len_nxt = len_r + wpm_pkg::LEN_W'(1);
    end
    if (ctrl.clear_txt) begin
      pos_nxt = '0;
      cnt_nxt = '0;
    end else if (text_take) begin
      pos_nxt = pos_inc;
      if (hit && (cnt_r < MAX_TEXT_C)) begin
        cnt_nxt = cnt_r + PW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (text_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: load on every text symbol taken, hold otherwise
  always_ff @(posedge clk) begin
    if (text_take) begin
      out_match_r <= hit;
      out_start_r <= start;
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(wpm_pkg::OUT_TDATA_W - 1 - 2 * PW){1'b0}},
                       out_cnt_r, out_start_r, out_match_r};

  a_len_tracks_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pval_c) == int'(len_r))
    else $error("pattern length disagrees with valid cells");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_TEXT_C)
    else $error("match count beyond saturation limit");

  a_text_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    text_take |=> out_valid_r)
    else $error("text transfer produced no result");

  a_match_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_match_r) |-> (out_start_r != '0) && (out_cnt_r != '0))
    else $error("match reported without start position or count");

endmodule
